@@ rtl/core/rscc_pkg.sv @@
// ----------------------------------------------------------------------------
// rscc_pkg: shared types and constants of the send credit controller
// Request and response records, configuration record, operation and status
// codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package rscc_pkg;

   // Parameter defaults
   localparam int MAX_QUEUE_DEPTH_DEF     = 4096;
   localparam int RESERVED_RECV_SLOTS_DEF = 3;
   localparam int INLINE_LIMIT_DEF        = 64;

   // Fixed limits
   localparam logic [12:0] RING_MAX    = 13'd4096;
   localparam logic [12:0] PEND_MAX    = 13'd8191;
   localparam logic [13:0] ACC_MAX     = 14'd16383;
   localparam logic [12:0] CAP_RESET   = 13'd129;

   // Operation codes
   localparam logic [2:0] OP_SEND      = 3'd0;
   localparam logic [2:0] OP_RECV_DATA = 3'd1;
   localparam logic [2:0] OP_RECV_ACK  = 3'd2;
   localparam logic [2:0] OP_SEND_DONE = 3'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RETRY = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_SEND_QUEUE_SIZE = 2'd0;
   localparam logic [1:0] REG_RECV_QUEUE_SIZE = 2'd1;
   localparam logic [1:0] REG_LOCAL_WINDOW    = 2'd2;
   localparam logic [1:0] REG_REMOTE_WINDOW   = 2'd3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [2:0]  op;
      logic        message_done;
      logic [15:0] payload_len;
      logic [15:0] recv_len;
      logic [12:0] credit_return;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] send_slot;
      logic        inline_flag;
      logic        solicited_flag;
      logic        signaled_flag;
      logic [12:0] piggy_credits;
      logic [12:0] recv_slot;
      logic        wake_writer;
      logic        send_pure_ack;
      logic [12:0] pure_ack_credits;
      logic [15:0] delivered_len;
   } rsp_type;

   typedef struct packed {
      logic [12:0] send_queue_size;
      logic [12:0] recv_queue_size;
      logic [12:0] local_window_capacity;
      logic [12:0] remote_window_capacity;
   } cfg_type;

   // Reload of the send window on a write of the local window capacity.
   typedef struct packed {
      logic        load;
      logic [12:0] value;
   } win_load_type;

endpackage

@@ rtl/core/rscc_if.sv @@
// ----------------------------------------------------------------------------
// rscc_if: request and response channels of the send credit controller
// Valid/ready channels carrying one request or one response record.
// ----------------------------------------------------------------------------
interface rscc_req_if;
   logic              valid;
   logic              ready;
   rscc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rscc_rsp_if;
   logic              valid;
   logic              ready;
   rscc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/rscc_csr.sv @@
// ----------------------------------------------------------------------------
// rscc_csr: configuration registers
// APB-style register file holding ring sizes and window capacities.
// ----------------------------------------------------------------------------
module rscc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rscc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [rscc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [rscc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output rscc_pkg::cfg_type                    cfg,
   output rscc_pkg::win_load_type               win_load
);

   rscc_pkg::cfg_type cfg_ff;
   rscc_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;
   logic [12:0]       wr_val;
   logic [12:0]       rd_val;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign wr_val  = pwdata[12:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rscc_pkg::REG_SEND_QUEUE_SIZE: cfg_in.send_queue_size        = wr_val;
            rscc_pkg::REG_RECV_QUEUE_SIZE: cfg_in.recv_queue_size        = wr_val;
            rscc_pkg::REG_LOCAL_WINDOW:    cfg_in.local_window_capacity  = wr_val;
            rscc_pkg::REG_REMOTE_WINDOW:   cfg_in.remote_window_capacity = wr_val;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.send_queue_size        <= rscc_pkg::CAP_RESET;
         cfg_ff.recv_queue_size        <= rscc_pkg::CAP_RESET;
         cfg_ff.local_window_capacity  <= rscc_pkg::CAP_RESET;
         cfg_ff.remote_window_capacity <= rscc_pkg::CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         rscc_pkg::REG_SEND_QUEUE_SIZE: rd_val = cfg_ff.send_queue_size;
         rscc_pkg::REG_RECV_QUEUE_SIZE: rd_val = cfg_ff.recv_queue_size;
         rscc_pkg::REG_LOCAL_WINDOW:    rd_val = cfg_ff.local_window_capacity;
         rscc_pkg::REG_REMOTE_WINDOW:   rd_val = cfg_ff.remote_window_capacity;
         default:                       rd_val = '0;
      endcase
   end

   assign prdata = {{(rscc_pkg::CSR_DATA_W - 13){1'b0}}, rd_val};

   assign cfg            = cfg_ff;
   assign win_load.load  = wr_en && (reg_idx == rscc_pkg::REG_LOCAL_WINDOW);
   assign win_load.value = wr_val;

endmodule

@@ rtl/core/rscc_engine.sv @@
// ----------------------------------------------------------------------------
// rscc_engine: credit and completion state with its single-pass update
// Holds the window, credit and ring pointer state and forms one response
// per request in combinational logic.
// ----------------------------------------------------------------------------
module rscc_engine #(
   parameter int MAX_QUEUE_DEPTH     = rscc_pkg::MAX_QUEUE_DEPTH_DEF,
   parameter int RESERVED_RECV_SLOTS = rscc_pkg::RESERVED_RECV_SLOTS_DEF,
   parameter int INLINE_LIMIT        = rscc_pkg::INLINE_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  rscc_pkg::req_type      req,
   input  rscc_pkg::cfg_type      cfg,
   input  rscc_pkg::win_load_type win_load,
   output rscc_pkg::rsp_type      rsp
);

   localparam int WinW = $clog2(MAX_QUEUE_DEPTH + 1);
   localparam int SumW = ((WinW > 13) ? WinW : 13) + 1;
   localparam logic [SumW-1:0] MaxDepth = SumW'(MAX_QUEUE_DEPTH);
   localparam logic [12:0]     Reserved = 13'(RESERVED_RECV_SLOTS);
   localparam logic [16:0]     InlineMax = 17'(INLINE_LIMIT);

   logic [WinW-1:0] window_ff,   window_in;
   logic [12:0]     pend_ff,     pend_in;
   logic [13:0]     acc_ff,      acc_in;
   logic [12:0]     unsol_ff,    unsol_in;
   logic [12:0]     unsig_ff,    unsig_in;
   logic [11:0]     head_ff,     head_in;
   logic [12:0]     rix_ff,      rix_in;

   logic [12:0]     sq_size;
   logic [12:0]     rq_size;
   logic [12:0]     rring;
   logic [10:0]     lwc_q;
   logic [10:0]     rwc_q;
   logic [11:0]     rwc_h;
   logic            window_zero;
   logic [12:0]     unsol_inc;
   logic [12:0]     unsig_inc;
   logic [14:0]     acc_sum;
   logic [13:0]     acc_sat;
   logic            sol;
   logic [12:0]     head_inc;
   logic [13:0]     rix_inc;
   logic [SumW-1:0] win_sum;
   logic [SumW-1:0] load_ext;
   logic [12:0]     pend_inc;
   logic [15:0]     len;

   // Ring sizes are clamped to 1..4096.
   always_comb begin
      if (cfg.send_queue_size == 13'd0) begin
         sq_size = 13'd1;
      end else if (cfg.send_queue_size > rscc_pkg::RING_MAX) begin
         sq_size = rscc_pkg::RING_MAX;
      end else begin
         sq_size = cfg.send_queue_size;
      end
      if (cfg.recv_queue_size == 13'd0) begin
         rq_size = 13'd1;
      end else if (cfg.recv_queue_size > rscc_pkg::RING_MAX) begin
         rq_size = rscc_pkg::RING_MAX;
      end else begin
         rq_size = cfg.recv_queue_size;
      end
   end

   assign rring = rq_size + Reserved;
   assign lwc_q = cfg.local_window_capacity[12:2];
   assign rwc_q = cfg.remote_window_capacity[12:2];
   assign rwc_h = cfg.remote_window_capacity[12:1];

   assign window_zero = (window_ff == '0);
   assign unsol_inc   = unsol_ff + 13'd1;
   assign unsig_inc   = unsig_ff + 13'd1;
   assign acc_sum     = {1'b0, acc_ff} + {2'b00, pend_ff};
   assign acc_sat     = (acc_sum > {1'b0, rscc_pkg::ACC_MAX}) ? rscc_pkg::ACC_MAX
                                                              : acc_sum[13:0];
   assign head_inc    = {1'b0, head_ff} + 13'd1;
   assign rix_inc     = {1'b0, rix_ff} + 14'd1;
   assign win_sum     = SumW'(window_ff) + SumW'(req.credit_return);
   assign load_ext    = SumW'(win_load.value);
   assign pend_inc    = (pend_ff < rscc_pkg::PEND_MAX) ? (pend_ff + 13'd1) : pend_ff;
   assign len         = (req.op == rscc_pkg::OP_RECV_DATA) ? req.recv_len : 16'd0;

   always_comb begin
      window_in = window_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      unsol_in  = unsol_ff;
      unsig_in  = unsig_ff;
      head_in   = head_ff;
      rix_in    = rix_ff;
      sol       = 1'b0;
      rsp       = '0;

      case (req.op)
         rscc_pkg::OP_SEND: begin
            if (window_zero) begin
               rsp.status = rscc_pkg::STATUS_RETRY;
            end else begin
               rsp.status        = rscc_pkg::STATUS_OK;
               rsp.send_slot     = head_ff;
               rsp.piggy_credits = pend_ff;
               rsp.inline_flag   = ({1'b0, req.payload_len} <= InlineMax);
               pend_in           = '0;
               if (req.message_done) begin
                  sol = 1'b1;
               end else begin
                  unsol_in = unsol_inc;
                  acc_in   = acc_sat;
                  sol      = (unsol_inc > {2'b00, lwc_q}) ||
                             (acc_sat > {3'b000, rwc_q});
               end
               if (sol) begin
                  unsol_in = '0;
                  acc_in   = '0;
               end
               rsp.solicited_flag = sol;
               // A zero quarter capacity makes every send signaled.
               if (unsig_inc >= {2'b00, lwc_q}) begin
                  rsp.signaled_flag = 1'b1;
                  unsig_in          = '0;
               end else begin
                  unsig_in = unsig_inc;
               end
               head_in   = (head_inc >= sq_size) ? 12'd0 : head_inc[11:0];
               window_in = window_ff - WinW'(1);
            end
         end
         rscc_pkg::OP_RECV_DATA, rscc_pkg::OP_RECV_ACK: begin
            rsp.status = rscc_pkg::STATUS_OK;
            if (req.credit_return != 13'd0) begin
               rsp.wake_writer = window_zero;
               window_in = (win_sum > MaxDepth) ? WinW'(MAX_QUEUE_DEPTH)
                                                : win_sum[WinW-1:0];
            end
            rsp.recv_slot = rix_ff;
            rix_in = (rix_inc >= {1'b0, rring}) ? 13'd0 : rix_inc[12:0];
            if (len != 16'd0) begin
               // The test uses the count before this completion is added.
               if ({1'b0, pend_ff} > {2'b00, rwc_h}) begin
                  rsp.send_pure_ack    = 1'b1;
                  rsp.pure_ack_credits = pend_inc;
                  pend_in              = '0;
               end else begin
                  pend_in = pend_inc;
               end
            end
            rsp.delivered_len = len;
         end
         rscc_pkg::OP_SEND_DONE: begin
            rsp.status = rscc_pkg::STATUS_OK;
         end
         default: begin
            rsp.status = rscc_pkg::STATUS_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= (SumW'(rscc_pkg::CAP_RESET) > MaxDepth) ? WinW'(MAX_QUEUE_DEPTH)
                                                            : WinW'(rscc_pkg::CAP_RESET);
         pend_ff   <= '0;
         acc_ff    <= '0;
         unsol_ff  <= '0;
         unsig_ff  <= '0;
         head_ff   <= '0;
         rix_ff    <= '0;
      end else if (win_load.load) begin
         window_ff <= (load_ext > MaxDepth) ? WinW'(MAX_QUEUE_DEPTH)
                                            : load_ext[WinW-1:0];
      end else if (step) begin
         window_ff <= window_in;
         pend_ff   <= pend_in;
         acc_ff    <= acc_in;
         unsol_ff  <= unsol_in;
         unsig_ff  <= unsig_in;
         head_ff   <= head_in;
         rix_ff    <= rix_in;
      end
   end

endmodule

@@ rtl/core/rdma_send_credit_controller_top.sv @@
// Path: an accepted request waits in the input register, then passes through the
// engine into the response register once that is free or draining.
// Throughput: one request per cycle while the response side does not stall; the
// credit state updates once per request. Reset: synchronous, active high; clears
// the stage valid bits and credit state and loads the configuration defaults of 129.
// ----------------------------------------------------------------------------
// rdma_send_credit_controller_top: send credit controller top level
// Input register, single-pass credit engine, response register and the
// configuration register file.
// ----------------------------------------------------------------------------
module rdma_send_credit_controller_top #(
   parameter int MAX_QUEUE_DEPTH     = rscc_pkg::MAX_QUEUE_DEPTH_DEF,
   parameter int RESERVED_RECV_SLOTS = rscc_pkg::RESERVED_RECV_SLOTS_DEF,
   parameter int INLINE_LIMIT        = rscc_pkg::INLINE_LIMIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rscc_req_if.sink                        req_chan,
   rscc_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rscc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rscc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rscc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   rscc_pkg::cfg_type      cfg;
   rscc_pkg::win_load_type win_load;
   rscc_pkg::req_type      in_data_ff;
   logic                   in_valid_ff, in_valid_in;
   rscc_pkg::rsp_type      rsp_data_ff;
   rscc_pkg::rsp_type      rsp_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance;
   logic                   in_ready;

   // The request moves on whenever the response register is free or drains.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign in_ready = !in_valid_ff || advance;

   assign req_chan.ready   = in_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_ready) begin
         in_valid_in = req_chan.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   rscc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .win_load (win_load)
   );

   rscc_engine #(
      .MAX_QUEUE_DEPTH     (MAX_QUEUE_DEPTH),
      .RESERVED_RECV_SLOTS (RESERVED_RECV_SLOTS),
      .INLINE_LIMIT        (INLINE_LIMIT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req      (in_data_ff),
      .cfg      (cfg),
      .win_load (win_load),
      .rsp      (rsp_next)
   );

endmodule

@@ tb/rscc_credit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rscc_credit_checker: response checker of the send credit controller
// Watches the request and response channels and the register port, keeps its
// own copy of the credit state and compares every response, field by field,
// with the prediction made when the matching request was accepted.
// ----------------------------------------------------------------------------
module rscc_credit_checker
   import rscc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rscc_req_if                   req_mon,
   rscc_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int unsigned           mismatch_count,
   output int unsigned           awaiting
);

   cfg_type     cfg;
   logic [12:0] window;
   logic [12:0] pending_credits;
   logic [13:0] acked_credits;
   logic [12:0] unsolicited;
   logic [12:0] unsignaled;
   logic [11:0] head_slot;
   logic [11:0] free_slot;
   logic [12:0] recv_ptr;
   rsp_type     expected_rsp_q[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [15:0] seen,
                              input logic [15:0] wanted);
      if (seen !== wanted) begin
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", field, seen, wanted));
      end
   endtask

   function automatic int unsigned ring_size(input logic [12:0] size);
      if (size == 0) return 1;
      if (size > RING_MAX) return RING_MAX;
      return size;
   endfunction

   // Advances the credit state by one request and returns its response.
   function automatic rsp_type credit_step(input req_type rq);
      rsp_type     r;
      int unsigned sq;
      int unsigned rring;
      int unsigned sum;
      int unsigned nxt;
      logic [12:0] piggy;
      logic [12:0] old_pending;
      logic [15:0] len;
      logic        sol;
      logic        sig;

      r  = '0;
      sq = ring_size(cfg.send_queue_size);
      case (rq.op)
         OP_SEND: begin
            if (window == 0) begin
               r.status = STATUS_RETRY;
            end else begin
               piggy           = pending_credits;
               pending_credits = '0;
               sol             = rq.message_done;
               sig             = 1'b0;
               if (!rq.message_done) begin
                  unsolicited   = unsolicited + 13'd1;
                  sum           = acked_credits + piggy;
                  acked_credits = (sum > ACC_MAX) ? ACC_MAX : 14'(sum);
                  sol = (unsolicited > cfg.local_window_capacity / 4) ||
                        (acked_credits > cfg.remote_window_capacity / 4);
               end
               if (sol) begin
                  unsolicited   = '0;
                  acked_credits = '0;
               end
               unsignaled = unsignaled + 13'd1;
               // A quarter capacity of zero makes every send signaled.
               if (unsignaled >= cfg.local_window_capacity / 4) begin
                  sig        = 1'b1;
                  unsignaled = '0;
               end
               r.status         = STATUS_OK;
               r.send_slot      = head_slot;
               r.inline_flag    = (rq.payload_len <= INLINE_LIMIT_DEF);
               r.solicited_flag = sol;
               r.signaled_flag  = sig;
               r.piggy_credits  = piggy;
               nxt       = head_slot + 1;
               head_slot = (nxt >= sq) ? '0 : 12'(nxt);
               window    = window - 13'd1;
            end
         end
         OP_RECV_DATA, OP_RECV_ACK: begin
            len   = (rq.op == OP_RECV_DATA) ? rq.recv_len : '0;
            rring = ring_size(cfg.recv_queue_size) + RESERVED_RECV_SLOTS_DEF;
            if (rq.credit_return != 0) begin
               nxt           = (free_slot >= sq) ? 0 : free_slot;
               free_slot     = 12'((nxt + rq.credit_return % sq) % sq);
               r.wake_writer = (window == 0);
               sum           = window + rq.credit_return;
               window = (sum > MAX_QUEUE_DEPTH_DEF) ? 13'(MAX_QUEUE_DEPTH_DEF) : 13'(sum);
            end
            r.recv_slot = recv_ptr;
            nxt         = recv_ptr + 1;
            recv_ptr    = (nxt >= rring) ? '0 : 13'(nxt);
            if (len != 0) begin
               old_pending = pending_credits;
               if (pending_credits < PEND_MAX) pending_credits = pending_credits + 13'd1;
               if (old_pending > cfg.remote_window_capacity / 2) begin
                  r.send_pure_ack    = 1'b1;
                  r.pure_ack_credits = pending_credits;
                  pending_credits    = '0;
               end
            end
            r.delivered_len = len;
         end
         OP_SEND_DONE: r.status = STATUS_OK;
         default:      r.status = STATUS_ERROR;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type     seen;
      rsp_type     wanted;
      logic [12:0] reg_value;

      if (reset) begin
         cfg             = '{CAP_RESET, CAP_RESET, CAP_RESET, CAP_RESET};
         window          = CAP_RESET;
         pending_credits = '0;
         acked_credits   = '0;
         unsolicited     = '0;
         unsignaled      = '0;
         head_slot       = '0;
         free_slot       = '0;
         recv_ptr        = '0;
         mismatch_count  = 0;
         expected_rsp_q.delete();
      end else begin
         if (psel && penable && pready) begin
            case (paddr[3:2])
               REG_SEND_QUEUE_SIZE: reg_value = cfg.send_queue_size;
               REG_RECV_QUEUE_SIZE: reg_value = cfg.recv_queue_size;
               REG_LOCAL_WINDOW:    reg_value = cfg.local_window_capacity;
               default:             reg_value = cfg.remote_window_capacity;
            endcase
            if (!pwrite && prdata !== CSR_DATA_W'(reg_value)) begin
               report_mismatch($sformatf("register read at 0x%0h: got 0x%0h, expected 0x%0h",
                                         paddr, prdata, reg_value));
            end
            if (pwrite) begin
               case (paddr[3:2])
                  REG_SEND_QUEUE_SIZE: cfg.send_queue_size = pwdata[12:0];
                  REG_RECV_QUEUE_SIZE: cfg.recv_queue_size = pwdata[12:0];
                  REG_LOCAL_WINDOW: begin
                     cfg.local_window_capacity = pwdata[12:0];
                     window = (pwdata[12:0] > MAX_QUEUE_DEPTH_DEF) ?
                              13'(MAX_QUEUE_DEPTH_DEF) : pwdata[12:0];
                  end
                  default: cfg.remote_window_capacity = pwdata[12:0];
               endcase
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = rsp_mon.payload;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response without an outstanding request");
            end else begin
               wanted = expected_rsp_q.pop_front();
               check_field("status", 16'(seen.status), 16'(wanted.status));
               check_field("send_slot", 16'(seen.send_slot), 16'(wanted.send_slot));
               check_field("inline_flag", 16'(seen.inline_flag), 16'(wanted.inline_flag));
               check_field("solicited_flag", 16'(seen.solicited_flag),
                           16'(wanted.solicited_flag));
               check_field("signaled_flag", 16'(seen.signaled_flag), 16'(wanted.signaled_flag));
               check_field("piggy_credits", 16'(seen.piggy_credits), 16'(wanted.piggy_credits));
               check_field("recv_slot", 16'(seen.recv_slot), 16'(wanted.recv_slot));
               check_field("wake_writer", 16'(seen.wake_writer), 16'(wanted.wake_writer));
               check_field("send_pure_ack", 16'(seen.send_pure_ack), 16'(wanted.send_pure_ack));
               check_field("pure_ack_credits", 16'(seen.pure_ack_credits),
                           16'(wanted.pure_ack_credits));
               check_field("delivered_len", seen.delivered_len, wanted.delivered_len);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            expected_rsp_q.push_back(credit_step(req_mon.payload));
         end
      end
      awaiting = expected_rsp_q.size();
   end

endmodule

@@ tb/tb_rdma_send_credit_controller_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rdma_send_credit_controller_top: testbench of the send credit controller
// Runs a directed set of requests, then random request streams under several
// register settings, with bursty requests and a stalling response side. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_rdma_send_credit_controller_top;
   import rscc_pkg::*;

   localparam int          CLOCK_HALF      = 2;
   localparam int          RESET_CYCLES    = 12;
   localparam int          SETTLE_CYCLES   = 6;
   localparam int          RSP_HOLD_CYCLES = 80;
   localparam int          N_PHASES        = 6;
   localparam int          PHASE_REQUESTS  = 165;
   localparam logic [2:0]  OP_ERROR        = 3'd4;
   localparam logic [2:0]  OP_LAST         = 3'd7;
   localparam logic [12:0] CREDIT_MAX      = 13'(MAX_QUEUE_DEPTH_DEF);

   typedef enum logic [1:0] {SEG_MIXED, SEG_SENDS, SEG_RECVS, SEG_NOISE} seg_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int unsigned           mismatches;
   int unsigned           awaiting;
   int unsigned           burst_left = 0;
   bit                    hold_rsp   = 1'b0;

   rscc_req_if req_if ();
   rscc_rsp_if rsp_if ();

   rdma_send_credit_controller_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   rscc_credit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatches),
      .awaiting       (awaiting)
   );

   always #(CLOCK_HALF) clock = ~clock;

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side: random stretches of always ready, mostly ready, mostly
   // stalled or toggling, plus a long hold-off whenever stimulus asks for one.
   initial begin
      int unsigned stretch;
      int unsigned mode;

      rsp_if.ready <= 1'b0;
      forever begin
         stretch = $urandom_range(8, 64);
         mode    = $urandom_range(0, 3);
         repeat (stretch) begin
            @(posedge clock);
            if (hold_rsp) begin
               rsp_if.ready <= 1'b0;
               repeat (RSP_HOLD_CYCLES) @(posedge clock);
               hold_rsp = 1'b0;
            end
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ~rsp_if.ready;
            endcase
         end
      end
   end

   function automatic req_type req_of(input logic [2:0] op, input logic done,
                                      input logic [15:0] plen, input logic [15:0] rlen,
                                      input logic [12:0] cret);
      req_type r;

      r.op            = op;
      r.message_done  = done;
      r.payload_len   = plen;
      r.recv_len      = rlen;
      r.credit_return = cret;
      return r;
   endfunction

   function automatic req_type make_request(input seg_kind_type kind);
      req_type     r;
      int unsigned pick;

      pick = $urandom_range(0, 99);
      case (kind)
         SEG_SENDS: r.op = (pick < 85) ? OP_SEND : (pick < 95) ? OP_RECV_DATA : OP_SEND_DONE;
         SEG_RECVS: r.op = (pick < 75) ? OP_RECV_DATA : (pick < 85) ? OP_RECV_ACK :
                           (pick < 95) ? OP_SEND : OP_SEND_DONE;
         SEG_MIXED: begin
            if (pick < 40)      r.op = OP_SEND;
            else if (pick < 70) r.op = OP_RECV_DATA;
            else if (pick < 82) r.op = OP_RECV_ACK;
            else if (pick < 90) r.op = OP_SEND_DONE;
            else                r.op = 3'($urandom_range(OP_ERROR, OP_LAST));
         end
         default: r.op = 3'($urandom_range(OP_SEND, OP_LAST));
      endcase
      r.message_done = ($urandom_range(0, 9) < 3);

      pick = $urandom_range(0, 99);
      if (pick < 30)      r.payload_len = 16'($urandom_range(0, 128));
      else if (pick < 40) r.payload_len = 16'(INLINE_LIMIT_DEF + $urandom_range(0, 1));
      else if (pick < 45) r.payload_len = 16'hFFFF;
      else                r.payload_len = 16'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 10)      r.recv_len = '0;
      else if (pick < 15) r.recv_len = 16'hFFFF;
      else                r.recv_len = 16'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 55)      r.credit_return = '0;
      else if (pick < 85) r.credit_return = 13'($urandom_range(1, 8));
      else if (pick < 97) r.credit_return = 13'($urandom_range(1, 300));
      else if (pick < 99) r.credit_return = CREDIT_MAX;
      else                r.credit_return = 13'($urandom_range(0, CREDIT_MAX));
      return r;
   endfunction

   // Offers one request and waits for the edge that accepts it. Within a
   // burst valid stays high and the next request follows at once; otherwise valid drops.
   task automatic push_request(input req_type item);
      int unsigned gap;

      req_if.payload <= item;
      req_if.valid   <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 12);
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic is_write, input logic [1:0] index,
                            input logic [12:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      cfg_type      setting;
      seg_kind_type kind;
      int unsigned  seg_left;
      int unsigned  pick;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      seg_left        = 0;
      kind            = SEG_MIXED;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, every operation and the window saturation at reset values.
      push_request(req_of(OP_SEND, 1'b1, 16'd0, 16'd0, 13'd0));
      push_request(req_of(OP_SEND, 1'b0, 16'(INLINE_LIMIT_DEF), 16'hFFFF, 13'd0));
      push_request(req_of(OP_SEND, 1'b0, 16'(INLINE_LIMIT_DEF + 1), 16'd0, 13'd0));
      push_request(req_of(OP_SEND, 1'b1, 16'hFFFF, 16'd0, CREDIT_MAX));
      push_request(req_of(OP_RECV_DATA, 1'b0, 16'd0, 16'd0, 13'd0));
      push_request(req_of(OP_RECV_DATA, 1'b1, 16'hFFFF, 16'hFFFF, CREDIT_MAX));
      push_request(req_of(OP_RECV_ACK, 1'b0, 16'd0, 16'd500, 13'd1));
      push_request(req_of(OP_SEND, 1'b0, 16'd1, 16'd0, 13'd0));
      push_request(req_of(OP_SEND_DONE, 1'b1, 16'hFFFF, 16'hFFFF, CREDIT_MAX));
      for (int code = OP_ERROR; code <= OP_LAST; code++) begin
         push_request(req_of(3'(code), 1'b1, 16'hFFFF, 16'hFFFF, CREDIT_MAX));
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         drain_responses();
         case (phase)
            0:       setting = '{CAP_RESET, CAP_RESET, CAP_RESET, CAP_RESET};
            1:       setting = '{13'd16, 13'd16, 13'd1, 13'd1};
            2:       setting = '{RING_MAX, RING_MAX, RING_MAX, RING_MAX};
            3:       setting = '{13'd20, 13'd37, 13'd8, 13'd6};
            4:       setting = '{RING_MAX, 13'd16, 13'd3, RING_MAX};
            default: setting = '{13'd33, RING_MAX, 13'd64, 13'd2};
         endcase
         csr_cycle(1'b1, REG_SEND_QUEUE_SIZE, setting.send_queue_size);
         csr_cycle(1'b1, REG_RECV_QUEUE_SIZE, setting.recv_queue_size);
         csr_cycle(1'b1, REG_LOCAL_WINDOW, setting.local_window_capacity);
         csr_cycle(1'b1, REG_REMOTE_WINDOW, setting.remote_window_capacity);
         csr_cycle(1'b0, REG_SEND_QUEUE_SIZE, '0);
         csr_cycle(1'b0, REG_RECV_QUEUE_SIZE, '0);
         csr_cycle(1'b0, REG_LOCAL_WINDOW, '0);
         csr_cycle(1'b0, REG_REMOTE_WINDOW, '0);

         if (phase == 1) begin
            // One credit: a refused send, a wake on returned credit, a pure
            // acknowledgement and a send with a zero quarter capacity.
            push_request(req_of(OP_SEND, 1'b0, 16'd10, 16'd0, 13'd0));
            push_request(req_of(OP_SEND, 1'b0, 16'd10, 16'd0, 13'd0));
            push_request(req_of(OP_RECV_DATA, 1'b0, 16'd0, 16'd1, 13'd0));
            push_request(req_of(OP_RECV_DATA, 1'b0, 16'd0, 16'd1, 13'd1));
            push_request(req_of(OP_SEND, 1'b1, 16'd100, 16'd0, 13'd0));
         end
         if (phase == 2 || phase == 4) hold_rsp = 1'b1;

         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (seg_left == 0) begin
               pick = $urandom_range(0, 9);
               kind = (pick < 3) ? SEG_SENDS : (pick < 6) ? SEG_RECVS :
                      (pick < 9) ? SEG_MIXED : SEG_NOISE;
               seg_left = $urandom_range(1, 100);
            end
            push_request(make_request(kind));
            seg_left--;
         end
      end

      drain_responses();
      if (mismatches == 0 && awaiting == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
